// ===== hw/rtl/bpba_pkg.sv =====
// Shared types, constants and codes for the block pool buffer allocator.
`default_nettype none

package bpba_pkg;

    // Pool geometry
    localparam int NUM_BLOCKS          = 64;
    localparam int BLOCK_HEADER_BYTES  = 32;
    localparam int BUFFER_HEADER_BYTES = 32;

    localparam int BLK_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
    localparam int SIZE_W     = 17;
    localparam int LEN_W      = 16;
    localparam int REF_W      = 16;
    localparam int BIU_W      = 7;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    typedef logic [BLK_W-1:0]    blk_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [SIZE_W-1:0]   size_t;
    typedef logic [LEN_W-1:0]    len_t;
    typedef logic [REF_W-1:0]    ref_t;
    typedef logic [BIU_W-1:0]    biu_t;
    typedef logic [OP_W-1:0]     op_code_t;
    typedef logic [STATUS_W-1:0] status_code_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // Operation codes
    localparam op_code_t OP_ALLOC_BUF   = 3'd0;
    localparam op_code_t OP_ALLOC_WHOLE = 3'd1;
    localparam op_code_t OP_ADD_REF     = 3'd2;
    localparam op_code_t OP_RELEASE     = 3'd3;
    localparam op_code_t OP_TRIM        = 3'd4;

    // Status codes
    localparam status_code_t ST_OK           = 3'd0;
    localparam status_code_t ST_TOO_LONG     = 3'd1;
    localparam status_code_t ST_NO_BLOCK     = 3'd2;
    localparam status_code_t ST_TEMP_REFUSED = 3'd3;
    localparam status_code_t ST_NO_REMAINDER = 3'd4;

    // Configuration register indexes
    localparam cfg_idx_t CFG_BLOCK_SIZE    = 2'd0;
    localparam cfg_idx_t CFG_BLOCKS_IN_USE = 2'd1;
    localparam cfg_idx_t CFG_MIN_REMAINDER = 2'd2;

    // Register reset values
    localparam size_t BLOCK_SIZE_RST    = 17'd4096;
    localparam biu_t  BLOCKS_IN_USE_RST = 7'd64;
    localparam len_t  MIN_REMAINDER_RST = 16'd64;

    typedef struct packed {
        size_t block_size;
        cnt_t  pool;
        len_t  min_remainder;
    } cfg_t;

    typedef struct packed {
        op_code_t operation;
        len_t     length;
        blk_t     block_index;
        len_t     data_offset;
        logic     reserve_allowed;
        logic     is_temporary;
    } req_t;

    typedef struct packed {
        status_code_t status;
        blk_t         result_block;
        len_t         result_offset;
        len_t         result_length;
        cnt_t         free_blocks;
    } rsp_t;

    // Current block is held in registers; its ref count in memory is stale while valid.
    typedef struct packed {
        logic  cur_valid;
        blk_t  cur_block;
        ref_t  cur_ref;
        size_t cur_fill;
        cnt_t  free_count;
    } pool_state_t;

    typedef struct packed {
        logic we;
        blk_t addr;
        blk_t data;
    } stk_wr_t;

    typedef struct packed {
        logic we;
        blk_t addr;
        ref_t data;
    } ref_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/block_pool_buffer_allocator_unit.sv =====
// Top level of the block pool buffer allocator: config, request stage, state, response.
`default_nettype none

// Channel    | Handshake            | Payload
// -----------+----------------------+------------------------------------------------
// request    | req_valid/req_ready  | operation, length, block_index, data_offset,
//            |                      | reserve_allowed, is_temporary
// response   | res_valid/res_ready  | status, result_block, result_offset,
//            |                      | result_length, free_blocks
// config     | cfg_we (no wait)     | cfg_index, cfg_data
//
// One request per cycle sustained while responses are taken; a response passes
// through the request register, then decode into the response register.
// The ref count and free stack memories are read ahead of decode, so the decode
// of each request sees every write of the one before it through forwarding.
// Reset needs no clearing pass: valid bits stand in for never-written entries.
// A held response stalls the request register, and req_ready drops only when
// both are full and the response is not being taken.

module block_pool_buffer_allocator_unit (
    input  wire                       clk,
    input  wire                       rst_n,

    input  wire                       cfg_we,
    input  bpba_pkg::cfg_idx_t        cfg_index,
    input  bpba_pkg::cfg_data_t       cfg_data,

    input  wire                       req_valid,
    output logic                      req_ready,
    input  bpba_pkg::op_code_t        operation,
    input  bpba_pkg::len_t            length,
    input  bpba_pkg::blk_t            block_index,
    input  bpba_pkg::len_t            data_offset,
    input  wire                       reserve_allowed,
    input  wire                       is_temporary,

    output logic                      res_valid,
    input  wire                       res_ready,
    output bpba_pkg::status_code_t    status,
    output bpba_pkg::blk_t            result_block,
    output bpba_pkg::len_t            result_offset,
    output bpba_pkg::len_t            result_length,
    output bpba_pkg::cnt_t            free_blocks
);
    import bpba_pkg::*;

    // Pool size is blocks_in_use clamped to the physical block count.
    function automatic cnt_t clamp_pool(input biu_t v);
        cnt_t r;
        r = cnt_t'(v);
        if (int'(v) > NUM_BLOCKS)
        begin
            r = cnt_t'(NUM_BLOCKS);
        end
        return r;
    endfunction

    // Configuration registers
    size_t block_size_reg;
    biu_t  blocks_in_use_reg;
    len_t  min_remainder_reg;

    // Request stage, pool state, response stage
    logic        req_valid_reg;
    req_t        req_reg;
    pool_state_t st_reg;
    logic        res_valid_reg;
    rsp_t        res_reg;

    cfg_t        cfg;
    req_t        req_in;
    logic        accept;
    logic        fire;
    logic        rebuild;
    cnt_t        new_pool;
    cnt_t        cnt_next;

    pool_state_t st_next;
    stk_wr_t     exec_stk_wr;
    ref_wr_t     exec_ref_wr;
    stk_wr_t     stk_wr;
    ref_wr_t     ref_wr;
    rsp_t        rsp;
    blk_t        stk_top;
    ref_t        ref_rd;

    assign cfg.block_size    = block_size_reg;
    assign cfg.pool          = clamp_pool(blocks_in_use_reg);
    assign cfg.min_remainder = min_remainder_reg;

    assign req_in.operation       = operation;
    assign req_in.length          = length;
    assign req_in.block_index     = block_index;
    assign req_in.data_offset     = data_offset;
    assign req_in.reserve_allowed = reserve_allowed;
    assign req_in.is_temporary    = is_temporary;

    // Decode fires when the response register is free or being drained.
    assign fire      = req_valid_reg && (!res_valid_reg || res_ready);
    assign req_ready = !req_valid_reg || fire;
    assign accept    = req_valid && req_ready;

    // A blocks_in_use write rebuilds the stack and drops the current block.
    assign rebuild  = cfg_we && (cfg_index == CFG_BLOCKS_IN_USE);
    assign new_pool = clamp_pool(cfg_data[BIU_W-1:0]);

    always_comb
    begin
        if (rebuild)
        begin
            cnt_next = new_pool;
        end
        else if (fire)
        begin
            cnt_next = st_next.free_count;
        end
        else
        begin
            cnt_next = st_reg.free_count;
        end
    end

    // On a rebuild the current block's live count is written back to memory.
    always_comb
    begin
        stk_wr = '0;
        ref_wr = '0;
        if (rebuild)
        begin
            ref_wr.we   = st_reg.cur_valid;
            ref_wr.addr = st_reg.cur_block;
            ref_wr.data = st_reg.cur_ref;
        end
        else if (fire)
        begin
            stk_wr = exec_stk_wr;
            ref_wr = exec_ref_wr;
        end
    end

    bpba_stack u_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .rebuild  (rebuild),
        .wr       (stk_wr),
        .cnt_next (cnt_next),
        .pool     (cfg.pool),
        .top      (stk_top)
    );

    bpba_refs u_refs (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (ref_wr),
        .rd_en   (accept),
        .rd_addr (block_index),
        .rd_data (ref_rd)
    );

    bpba_exec u_exec (
        .req     (req_reg),
        .st      (st_reg),
        .cfg     (cfg),
        .stk_top (stk_top),
        .ref_rd  (ref_rd),
        .st_next (st_next),
        .stk_wr  (exec_stk_wr),
        .ref_wr  (exec_ref_wr),
        .rsp     (rsp)
    );

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg    <= BLOCK_SIZE_RST;
            blocks_in_use_reg <= BLOCKS_IN_USE_RST;
            min_remainder_reg <= MIN_REMAINDER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BLOCK_SIZE:    block_size_reg    <= cfg_data[SIZE_W-1:0];
                CFG_BLOCKS_IN_USE: blocks_in_use_reg <= cfg_data[BIU_W-1:0];
                CFG_MIN_REMAINDER: min_remainder_reg <= cfg_data[LEN_W-1:0];
                default:           block_size_reg    <= block_size_reg;
            endcase
        end
    end

    // Pool state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.cur_valid  <= 1'b0;
            st_reg.cur_block  <= '0;
            st_reg.cur_ref    <= '0;
            st_reg.cur_fill   <= '0;
            st_reg.free_count <= clamp_pool(BLOCKS_IN_USE_RST);
        end
        else if (rebuild)
        begin
            st_reg.free_count <= new_pool;
            st_reg.cur_valid  <= 1'b0;
            st_reg.cur_block  <= '0;
        end
        else if (fire)
        begin
            st_reg <= st_next;
        end
    end

    // Request and response handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                req_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                req_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_in;
        end
        if (fire)
        begin
            res_reg <= rsp;
        end
    end

    assign res_valid     = res_valid_reg;
    assign status        = res_reg.status;
    assign result_block  = res_reg.result_block;
    assign result_offset = res_reg.result_offset;
    assign result_length = res_reg.result_length;
    assign free_blocks   = res_reg.free_blocks;

endmodule

`default_nettype wire

// ===== hw/rtl/bpba_stack.sv =====
// Free block stack: memory with per-entry valid bits and a registered top read.
`default_nettype none

module bpba_stack (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  rebuild,
    input  bpba_pkg::stk_wr_t    wr,
    input  bpba_pkg::cnt_t       cnt_next,
    input  bpba_pkg::cnt_t       pool,
    output bpba_pkg::blk_t       top
);
    import bpba_pkg::*;

    blk_t                  mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] vld_reg;
    blk_t                  rd_reg;
    blk_t                  addr_reg;
    logic                  vld_bit_reg;
    logic                  fwd_reg;
    blk_t                  fwd_data_reg;

    cnt_t raddr_full;
    blk_t raddr;
    cnt_t dflt;

    // Read the entry that will be on top after this edge.
    assign raddr_full = cnt_next - cnt_t'(1);
    assign raddr      = raddr_full[BLK_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_reg       <= mem[raddr];
        addr_reg     <= raddr;
        fwd_data_reg <= wr.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            vld_bit_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            if (rebuild)
            begin
                vld_reg <= '0;
            end
            else if (wr.we)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            vld_bit_reg <= vld_reg[raddr] && !rebuild;
            fwd_reg     <= wr.we && (wr.addr == raddr);
        end
    end

    // Unwritten entries hold the rebuilt order: pool-1 at the bottom, 0 on top.
    assign dflt = pool - cnt_t'(1) - cnt_t'(addr_reg);

    always_comb
    begin
        if (fwd_reg)
        begin
            top = fwd_data_reg;
        end
        else if (vld_bit_reg)
        begin
            top = rd_reg;
        end
        else
        begin
            top = dflt[BLK_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bpba_refs.sv =====
// Reference count memory with valid bits, registered read and write forwarding.
`default_nettype none

module bpba_refs (
    input  wire                  clk,
    input  wire                  rst_n,
    input  bpba_pkg::ref_wr_t    wr,
    input  wire                  rd_en,
    input  bpba_pkg::blk_t       rd_addr,
    output bpba_pkg::ref_t       rd_data
);
    import bpba_pkg::*;

    ref_t                  mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] vld_reg;
    ref_t                  rd_reg;
    logic                  vld_bit_reg;
    logic                  fwd_reg;
    ref_t                  fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_reg       <= mem[rd_addr];
            fwd_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            vld_bit_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_bit_reg <= vld_reg[rd_addr];
                fwd_reg     <= wr.we && (wr.addr == rd_addr);
            end
        end
    end

    // Never-written counts read as zero.
    assign rd_data = fwd_reg ? fwd_data_reg : (vld_bit_reg ? rd_reg : '0);

endmodule

`default_nettype wire

// ===== hw/rtl/bpba_exec.sv =====
// Single-pass request decode: next pool state, memory writes and response.
`default_nettype none

module bpba_exec (
    input  bpba_pkg::req_t        req,
    input  bpba_pkg::pool_state_t st,
    input  bpba_pkg::cfg_t        cfg,
    input  bpba_pkg::blk_t        stk_top,
    input  bpba_pkg::ref_t        ref_rd,
    output bpba_pkg::pool_state_t st_next,
    output bpba_pkg::stk_wr_t     stk_wr,
    output bpba_pkg::ref_wr_t     ref_wr,
    output bpba_pkg::rsp_t        rsp
);
    import bpba_pkg::*;

    localparam size_t BUF_HDR     = size_t'(BUFFER_HEADER_BYTES);
    localparam size_t BLK_HDR     = size_t'(BLOCK_HEADER_BYTES);
    localparam size_t FIRST_DATA  = size_t'(BLOCK_HEADER_BYTES + BUFFER_HEADER_BYTES);
    localparam size_t WHOLE_OVH   = size_t'(BLOCK_HEADER_BYTES + 2 * BUFFER_HEADER_BYTES);
    localparam ref_t  REF_MAX     = '1;

    function automatic len_t sat_len(input size_t v);
        len_t r;
        r = v[LEN_W-1:0];
        if (v > size_t'({LEN_W{1'b1}}))
        begin
            r = '1;
        end
        return r;
    endfunction

    function automatic ref_t ref_inc(input ref_t v);
        return (v == REF_MAX) ? v : v + ref_t'(1);
    endfunction

    logic [SIZE_W:0] len_need;
    logic [SIZE_W:0] fit_need;
    logic            too_long;
    logic            fits;
    size_t           cur_data;
    logic            whole_ok;
    size_t           whole_len;
    logic            idx_ok;
    logic            is_cur;
    ref_t            ref_val;
    logic            room;
    logic            rel;
    logic            rel_dec;
    logic            rel_push;
    cnt_t            cnt1;
    logic            can1;
    logic            can0;
    blk_t            pop_blk;
    size_t           tfill;
    size_t           left;
    logic            carve_ok;
    size_t           rlen;
    size_t           tdata;

    assign len_need  = (SIZE_W+1)'(req.length) + (SIZE_W+1)'(FIRST_DATA);
    assign too_long  = len_need > (SIZE_W+1)'(cfg.block_size);
    assign fit_need  = (SIZE_W+1)'(st.cur_fill) + (SIZE_W+1)'(BUF_HDR)
                     + (SIZE_W+1)'(req.length);
    assign fits      = fit_need <= (SIZE_W+1)'(cfg.block_size);
    assign cur_data  = st.cur_fill + BUF_HDR;

    assign whole_ok  = cfg.block_size >= WHOLE_OVH;
    assign whole_len = cfg.block_size - WHOLE_OVH;

    assign idx_ok    = cnt_t'(req.block_index) < cfg.pool;
    assign is_cur    = st.cur_valid && (req.block_index == st.cur_block);
    assign ref_val   = is_cur ? st.cur_ref : ref_rd;
    assign room      = st.free_count < cnt_t'(NUM_BLOCKS);

    // alloc_buf: drop a full current block, then pop if needed
    assign rel       = st.cur_valid && !fits;
    assign rel_dec   = rel && (st.cur_ref != '0);
    assign rel_push  = rel_dec && (st.cur_ref == ref_t'(1)) && room;
    assign cnt1      = st.free_count + cnt_t'(rel_push);
    assign can1      = req.reserve_allowed ? (cnt1 != '0) : (cnt1 >= cnt_t'(2));
    assign can0      = req.reserve_allowed ? (st.free_count != '0)
                                           : (st.free_count >= cnt_t'(2));
    assign pop_blk   = rel_push ? st.cur_block : stk_top;

    // trim
    assign tfill     = size_t'(req.data_offset) + size_t'(req.length);
    assign left      = (tfill > cfg.block_size) ? '0 : cfg.block_size - tfill;
    assign carve_ok  = (left >= size_t'(cfg.min_remainder)) && (left >= BUF_HDR);
    assign rlen      = left - BUF_HDR;
    assign tdata     = tfill + BUF_HDR;

    always_comb
    begin
        st_next           = st;
        stk_wr            = '0;
        ref_wr            = '0;
        rsp               = '0;
        rsp.status        = ST_OK;

        unique case (req.operation)
            OP_ALLOC_BUF:
            begin
                if (too_long)
                begin
                    rsp.status = ST_TOO_LONG;
                end
                else
                begin
                    if (rel)
                    begin
                        st_next.cur_valid = 1'b0;
                        ref_wr.we   = 1'b1;
                        ref_wr.addr = st.cur_block;
                        ref_wr.data = rel_dec ? st.cur_ref - ref_t'(1) : st.cur_ref;
                        if (rel_push)
                        begin
                            stk_wr.we   = 1'b1;
                            stk_wr.addr = st.free_count[BLK_W-1:0];
                            stk_wr.data = st.cur_block;
                        end
                    end
                    st_next.free_count = cnt1;
                    if (!st.cur_valid || rel)
                    begin
                        if (can1)
                        begin
                            st_next.cur_valid  = 1'b1;
                            st_next.cur_block  = pop_blk;
                            st_next.cur_ref    = ref_t'(2);
                            st_next.cur_fill   = FIRST_DATA + size_t'(req.length);
                            st_next.free_count = cnt1 - cnt_t'(1);
                            rsp.result_block   = pop_blk;
                            rsp.result_offset  = FIRST_DATA[LEN_W-1:0];
                            rsp.result_length  = req.length;
                        end
                        else
                        begin
                            rsp.status = ST_NO_BLOCK;
                        end
                    end
                    else
                    begin
                        st_next.cur_ref   = ref_inc(st.cur_ref);
                        st_next.cur_fill  = fit_need[SIZE_W-1:0];
                        rsp.result_block  = st.cur_block;
                        rsp.result_offset = cur_data[LEN_W-1:0];
                        rsp.result_length = req.length;
                    end
                end
            end

            OP_ALLOC_WHOLE:
            begin
                if (!whole_ok)
                begin
                    rsp.status = ST_TOO_LONG;
                end
                else if (!can0)
                begin
                    rsp.status = ST_NO_BLOCK;
                end
                else
                begin
                    st_next.free_count = st.free_count - cnt_t'(1);
                    if (st.cur_valid && (stk_top == st.cur_block))
                    begin
                        st_next.cur_ref  = ref_t'(1);
                        st_next.cur_fill = cfg.block_size - BLK_HDR;
                    end
                    else
                    begin
                        ref_wr.we   = 1'b1;
                        ref_wr.addr = stk_top;
                        ref_wr.data = ref_t'(1);
                    end
                    rsp.result_block  = stk_top;
                    rsp.result_offset = FIRST_DATA[LEN_W-1:0];
                    rsp.result_length = sat_len(whole_len);
                end
            end

            OP_ADD_REF:
            begin
                if (req.is_temporary)
                begin
                    rsp.status = ST_TEMP_REFUSED;
                end
                else if (idx_ok)
                begin
                    if (is_cur)
                    begin
                        st_next.cur_ref = ref_inc(ref_val);
                    end
                    else
                    begin
                        ref_wr.we   = 1'b1;
                        ref_wr.addr = req.block_index;
                        ref_wr.data = ref_inc(ref_val);
                    end
                    rsp.result_block = req.block_index;
                end
            end

            OP_RELEASE:
            begin
                if (req.is_temporary)
                begin
                    rsp.status = ST_TEMP_REFUSED;
                end
                else if (idx_ok && (ref_val != '0))
                begin
                    if (is_cur)
                    begin
                        st_next.cur_ref = ref_val - ref_t'(1);
                    end
                    else
                    begin
                        ref_wr.we   = 1'b1;
                        ref_wr.addr = req.block_index;
                        ref_wr.data = ref_val - ref_t'(1);
                    end
                    // last reference gone: block goes back on the stack if it has room
                    if ((ref_val == ref_t'(1)) && room)
                    begin
                        stk_wr.we   = 1'b1;
                        stk_wr.addr = st.free_count[BLK_W-1:0];
                        stk_wr.data = req.block_index;
                        st_next.free_count = st.free_count + cnt_t'(1);
                    end
                end
            end

            OP_TRIM:
            begin
                if (!idx_ok)
                begin
                    rsp.status = ST_NO_REMAINDER;
                end
                else
                begin
                    if (is_cur)
                    begin
                        st_next.cur_fill = carve_ok ? cfg.block_size : tfill;
                    end
                    if (carve_ok)
                    begin
                        if (is_cur)
                        begin
                            st_next.cur_ref = ref_inc(ref_val);
                        end
                        else
                        begin
                            ref_wr.we   = 1'b1;
                            ref_wr.addr = req.block_index;
                            ref_wr.data = ref_inc(ref_val);
                        end
                        rsp.result_block  = req.block_index;
                        rsp.result_offset = tdata[LEN_W-1:0];
                        rsp.result_length = sat_len(rlen);
                    end
                    else
                    begin
                        rsp.status = ST_NO_REMAINDER;
                    end
                end
            end

            default:
            begin
                rsp.status = ST_OK;
            end
        endcase

        rsp.free_blocks = st_next.free_count;
    end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the block pool buffer allocator: shadow pool, random traffic.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bpba_pkg::*;

    // Generous bound on the length of a correct run.
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int PHASES         = 12;
    localparam int PHASE_REQUESTS = 95;

    logic       clk;
    logic       rst_n           = 1'b0;
    logic       cfg_we          = 1'b0;
    cfg_idx_t   cfg_index       = CFG_BLOCK_SIZE;
    cfg_data_t  cfg_data        = '0;
    logic       req_valid       = 1'b0;
    logic       req_ready;
    op_code_t   operation       = OP_ALLOC_BUF;
    len_t       length          = '0;
    blk_t       block_index     = '0;
    len_t       data_offset     = '0;
    logic       reserve_allowed = 1'b0;
    logic       is_temporary    = 1'b0;
    logic       res_valid;
    logic       res_ready       = 1'b0;
    status_code_t status;
    blk_t       result_block;
    len_t       result_offset;
    len_t       result_length;
    cnt_t       free_blocks;

    // Idle rates in percent of cycles, changed per stretch of the run
    int         send_idle_pct = 22;
    int         recv_idle_pct = 50;
    int         cycles        = 0;
    rsp_t       seen_rsp;

    // A buffer that has been handed out, kept so later requests can target it
    typedef struct {
        blk_t blk;
        len_t off;
        len_t len;
    } buf_rec_t;

    // Shadow of the allocator state plus the queue of responses still owed.
    class pool_shadow;
        size_t    blk_size;
        biu_t     pool_cfg;
        len_t     min_rem;
        blk_t     free_stack [NUM_BLOCKS];
        cnt_t     free_cnt;
        ref_t     refs [NUM_BLOCKS];
        size_t    fill [NUM_BLOCKS];
        blk_t     cur_blk;
        bit       cur_ok;
        rsp_t     responses_due [$];
        buf_rec_t live [$];
        int       mismatches;
        int       responses;

        function new();
            blk_size = BLOCK_SIZE_RST;
            pool_cfg = BLOCKS_IN_USE_RST;
            min_rem  = MIN_REMAINDER_RST;
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                refs[i]       = '0;
                fill[i]       = '0;
                free_stack[i] = '0;
            end
            mismatches = 0;
            responses  = 0;
            rebuild_stack();
        endfunction

        function int pool_blocks();
            return (int'(pool_cfg) > NUM_BLOCKS) ? NUM_BLOCKS : int'(pool_cfg);
        endfunction

        // Blocks 0..n-1 with block 0 on top
        function void rebuild_stack();
            int n;
            n = pool_blocks();
            for (int i = 0; i < n; i++)
                free_stack[i] = blk_t'(n - 1 - i);
            free_cnt = cnt_t'(n);
            cur_ok   = 1'b0;
            cur_blk  = '0;
        endfunction

        function void apply_config(cfg_idx_t idx, int value);
            case (idx)
                CFG_BLOCK_SIZE:    blk_size = size_t'(value);
                CFG_BLOCKS_IN_USE:
                begin
                    pool_cfg = biu_t'(value);
                    rebuild_stack();
                end
                CFG_MIN_REMAINDER: min_rem = len_t'(value);
                default: ;
            endcase
        endfunction

        // Push onto a full stack is dropped
        function void push_free(blk_t b);
            if (int'(free_cnt) < NUM_BLOCKS)
            begin
                free_stack[free_cnt[BLK_W-1:0]] = b;
                free_cnt++;
            end
        endfunction

        function void ref_up(blk_t b);
            if (refs[b] != '1)
                refs[b]++;
        endfunction

        function void ref_down(blk_t b);
            if (refs[b] == '0)
                return;
            refs[b]--;
            if (refs[b] == '0)
                push_free(b);
        endfunction

        function bit can_take(logic reserve);
            return reserve ? (free_cnt >= 1) : (free_cnt >= 2);
        endfunction

        function blk_t take_block();
            blk_t b;
            free_cnt--;
            b       = free_stack[free_cnt[BLK_W-1:0]];
            refs[b] = '0;
            fill[b] = size_t'(BLOCK_HEADER_BYTES);
            return b;
        endfunction

        // Carve len data bytes at the fill point; returns the data offset
        function int carve_at(blk_t b, int len);
            int data;
            data    = int'(fill[b]) + BUFFER_HEADER_BYTES;
            fill[b] = size_t'(data + len);
            ref_up(b);
            return data;
        endfunction

        function bit fits(blk_t b, int len);
            return int'(fill[b]) + BUFFER_HEADER_BYTES + len <= int'(blk_size);
        endfunction

        // Work out the response to an accepted request and queue it
        function void note_request(req_t rq);
            rsp_t         r;
            status_code_t st;
            int           rb, ro, rl, lim, fill_sum, left;
            bit           idx_ok;
            blk_t         b;
            buf_rec_t     rec;
            st     = ST_OK;
            rb     = 0;
            ro     = 0;
            rl     = 0;
            idx_ok = int'(rq.block_index) < pool_blocks();
            case (rq.operation)
                OP_ALLOC_BUF:
                begin
                    lim = int'(blk_size) - BLOCK_HEADER_BYTES - BUFFER_HEADER_BYTES;
                    if (int'(rq.length) > lim)
                        st = ST_TOO_LONG;
                    else
                    begin
                        // full current block is let go even if the pop fails
                        if (cur_ok && !fits(cur_blk, int'(rq.length)))
                        begin
                            cur_ok = 1'b0;
                            ref_down(cur_blk);
                        end
                        if (!cur_ok)
                        begin
                            if (can_take(rq.reserve_allowed))
                            begin
                                cur_blk = take_block();
                                cur_ok  = 1'b1;
                                ref_up(cur_blk);
                            end
                            else
                                st = ST_NO_BLOCK;
                        end
                        if (st == ST_OK)
                        begin
                            rb = int'(cur_blk);
                            ro = carve_at(cur_blk, int'(rq.length));
                            rl = int'(rq.length);
                        end
                    end
                end
                OP_ALLOC_WHOLE:
                begin
                    lim = int'(blk_size) - BLOCK_HEADER_BYTES - 2 * BUFFER_HEADER_BYTES;
                    if (lim < 0)
                        st = ST_TOO_LONG;
                    else if (!can_take(rq.reserve_allowed))
                        st = ST_NO_BLOCK;
                    else
                    begin
                        b  = take_block();
                        rb = int'(b);
                        ro = carve_at(b, lim);
                        rl = lim;
                    end
                end
                OP_ADD_REF:
                begin
                    if (rq.is_temporary)
                        st = ST_TEMP_REFUSED;
                    else if (idx_ok)
                    begin
                        ref_up(rq.block_index);
                        rb = int'(rq.block_index);
                    end
                end
                OP_RELEASE:
                begin
                    if (rq.is_temporary)
                        st = ST_TEMP_REFUSED;
                    else if (idx_ok)
                        ref_down(rq.block_index);
                end
                OP_TRIM:
                begin
                    if (!idx_ok)
                        st = ST_NO_REMAINDER;
                    else
                    begin
                        fill_sum = int'(rq.data_offset) + int'(rq.length);
                        left     = (fill_sum > int'(blk_size)) ? 0 : int'(blk_size) - fill_sum;
                        fill[rq.block_index] = size_t'(fill_sum);
                        if (left < int'(min_rem) || left < BUFFER_HEADER_BYTES)
                            st = ST_NO_REMAINDER;
                        else
                        begin
                            rl = left - BUFFER_HEADER_BYTES;
                            rb = int'(rq.block_index);
                            ro = carve_at(rq.block_index, rl);
                        end
                    end
                end
                default: ;
            endcase
            if (rl > 65535)
                rl = 65535;
            r.status        = st;
            r.result_block  = blk_t'(rb);
            r.result_offset = len_t'(ro);
            r.result_length = len_t'(rl);
            r.free_blocks   = free_cnt;
            responses_due.push_back(r);
            if (st == ST_OK && (rq.operation == OP_ALLOC_BUF || rq.operation == OP_ALLOC_WHOLE
                                || rq.operation == OP_TRIM))
            begin
                rec.blk = r.result_block;
                rec.off = r.result_offset;
                rec.len = r.result_length;
                live.push_back(rec);
                if (live.size() > 48)
                    void'(live.pop_front());
            end
        endfunction

        task report_mismatch(string field, logic [31:0] got_v, logic [31:0] want_v);
            if (mismatches < 100)
                $display("ERROR: response %0d, %s: got %0d, expected %0d",
                         responses, field, got_v, want_v);
            mismatches++;
        endtask

        task check_response(rsp_t got);
            rsp_t want;
            responses++;
            if (responses_due.size() == 0)
            begin
                report_mismatch("response with nothing outstanding", 32'(got.status), 32'd0);
                return;
            end
            want = responses_due.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.result_block !== want.result_block)
                report_mismatch("result_block", 32'(got.result_block),
                                32'(want.result_block));
            if (got.result_offset !== want.result_offset)
                report_mismatch("result_offset", 32'(got.result_offset),
                                32'(want.result_offset));
            if (got.result_length !== want.result_length)
                report_mismatch("result_length", 32'(got.result_length),
                                32'(want.result_length));
            if (got.free_blocks !== want.free_blocks)
                report_mismatch("free_blocks", 32'(got.free_blocks),
                                32'(want.free_blocks));
        endtask
    endclass

    pool_shadow sb;

    block_pool_buffer_allocator_unit DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hang anywhere ends the run as a failure
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Response side: take the response seen at this edge, then pick next ready.
    // Everything sampled here is the pre-edge value since all drives are NBAs.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            seen_rsp.status        = status;
            seen_rsp.result_block  = result_block;
            seen_rsp.result_offset = result_offset;
            seen_rsp.result_length = result_length;
            seen_rsp.free_blocks   = free_blocks;
            sb.check_response(seen_rsp);
        end
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic req_t make_request(op_code_t op, int len, int bi, int doff,
                                          bit reserve, bit temp);
        req_t rq;
        rq.operation       = op;
        rq.length          = len_t'(len);
        rq.block_index     = blk_t'(bi);
        rq.data_offset     = len_t'(doff);
        rq.reserve_allowed = reserve;
        rq.is_temporary    = temp;
        return rq;
    endfunction

    // Mostly well-formed traffic aimed at live buffers, with some noise mixed in
    function automatic req_t random_request();
        req_t     rq;
        int       pick, k, lim, lim16;
        buf_rec_t rec;
        rq.operation       = OP_ALLOC_BUF;
        rq.length          = len_t'($urandom);
        rq.block_index     = blk_t'($urandom_range(63));
        rq.data_offset     = len_t'($urandom);
        rq.reserve_allowed = 1'($urandom_range(1));
        rq.is_temporary    = ($urandom_range(9) == 0);
        lim   = int'(sb.blk_size) - BLOCK_HEADER_BYTES - BUFFER_HEADER_BYTES;
        lim16 = (lim > 65535) ? 65535 : lim;
        pick  = $urandom_range(99);
        if (pick < 34)
        begin
            k = $urandom_range(9);
            if (lim < 0)
                rq.length = len_t'($urandom_range(40));
            else if (k <= 5)
                rq.length = len_t'($urandom_range(lim16 / 8));
            else if (k == 6)
                rq.length = len_t'(lim16);
            else if (k == 7 && lim < 65535)
                rq.length = len_t'(lim + 1);
            else if (k == 9)
                rq.length = len_t'($urandom_range(lim16));
        end
        else if (pick < 44)
            rq.operation = OP_ALLOC_WHOLE;
        else if (pick < 58)
        begin
            rq.operation = OP_ADD_REF;
            if (sb.live.size() > 0 && $urandom_range(9) < 7)
                rq.block_index = sb.live[$urandom_range(sb.live.size() - 1)].blk;
        end
        else if (pick < 80)
        begin
            rq.operation = OP_RELEASE;
            if (sb.live.size() > 0 && $urandom_range(9) < 8)
            begin
                k = $urandom_range(sb.live.size() - 1);
                rq.block_index = sb.live[k].blk;
                sb.live.delete(k);
            end
        end
        else if (pick < 96)
        begin
            rq.operation = OP_TRIM;
            if (sb.live.size() > 0 && $urandom_range(9) < 7)
            begin
                rec = sb.live[$urandom_range(sb.live.size() - 1)];
                rq.block_index = rec.blk;
                rq.data_offset = rec.off;
                rq.length      = len_t'($urandom_range(int'(rec.len)));
            end
        end
        else
            rq.operation = op_code_t'($urandom_range(5, 7));
        return rq;
    endfunction

    // Present one request after a random gap; hold it until taken
    task automatic send_request(input req_t rq);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid       <= 1'b1;
        operation       <= rq.operation;
        length          <= rq.length;
        block_index     <= rq.block_index;
        data_offset     <= rq.data_offset;
        reserve_allowed <= rq.reserve_allowed;
        is_temporary    <= rq.is_temporary;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(rq);
    endtask

    task automatic write_register(input cfg_idx_t idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= cfg_data_t'(value);
        @(posedge clk);
        sb.apply_config(idx, value);
    endtask

    // Config changes only once every owed response has come back
    task automatic drain_responses();
        while (sb.responses_due.size() != 0)
            @(posedge clk);
    endtask

    // Fixed corner settings first, then random ones
    task automatic configure_phase(input int p);
        int bs, pool, minr;
        case (p)
            1:       begin bs = 256;    pool = 4;   minr = 0;     end
            2:       begin bs = 65536;  pool = 64;  minr = 65535; end
            3:       begin bs = 131071; pool = 127; minr = 32;    end  // wide lengths, clamp
            4:       begin bs = 90;     pool = 3;   minr = 10;    end  // whole block too long
            5:       begin bs = 50;     pool = 2;   minr = 5;     end  // every length too long
            6:       begin bs = 1024;   pool = 1;   minr = 200;   end
            default:
            begin
                bs   = ($urandom_range(3) == 0) ? $urandom_range(256, 65536)
                                                : $urandom_range(256, 4096);
                pool = $urandom_range(1, 64);
                minr = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(300);
            end
        endcase
        write_register(CFG_BLOCK_SIZE, bs);
        write_register(CFG_MIN_REMAINDER, minr);
        write_register(CFG_BLOCKS_IN_USE, pool);
        cfg_we <= 1'b0;
    endtask

    // Directed opening at reset settings (4096-byte blocks, 64 blocks, remainder 64)
    task automatic run_directed();
        // push onto a full stack is dropped; release at zero count does nothing
        send_request(make_request(OP_ADD_REF, 0, 5, 0, 0, 0));
        send_request(make_request(OP_RELEASE, 0, 5, 0, 0, 0));
        send_request(make_request(OP_RELEASE, 0, 5, 0, 0, 0));
        // first buffer pops block 0; too long; exact max forces a new block
        send_request(make_request(OP_ALLOC_BUF, 0, 0, 0, 0, 0));
        send_request(make_request(OP_ALLOC_BUF, 65535, 0, 0, 0, 0));
        send_request(make_request(OP_ALLOC_BUF, 4032, 0, 0, 0, 0));
        send_request(make_request(OP_ALLOC_BUF, 4033, 0, 0, 1, 0));
        send_request(make_request(OP_ALLOC_BUF, 0, 0, 0, 0, 0));
        send_request(make_request(OP_ALLOC_WHOLE, 0, 0, 0, 1, 0));
        send_request(make_request(OP_ALLOC_WHOLE, 0, 0, 0, 0, 0));
        // temporary buffers are refused
        send_request(make_request(OP_ADD_REF, 0, 0, 0, 0, 1));
        send_request(make_request(OP_RELEASE, 0, 0, 0, 0, 1));
        send_request(make_request(OP_ADD_REF, 0, 63, 0, 0, 0));
        send_request(make_request(OP_RELEASE, 0, 63, 0, 0, 0));
        // trim: remainder carved, overrun, leftover under the minimum
        send_request(make_request(OP_TRIM, 100, 3, 64, 0, 0));
        send_request(make_request(OP_TRIM, 65535, 3, 65535, 0, 0));
        send_request(make_request(OP_TRIM, 56, 3, 4000, 0, 0));
        send_request(make_request(OP_TRIM, 4000, 2, 64, 0, 0));
        send_request(make_request(OP_RELEASE, 0, 0, 0, 0, 0));
        send_request(make_request(OP_RELEASE, 0, 1, 0, 0, 0));
        send_request(make_request(OP_ALLOC_BUF, 200, 0, 0, 0, 0));
        // unknown operation codes
        send_request(make_request(op_code_t'(5), $urandom, $urandom, $urandom, 1, 1));
        send_request(make_request(op_code_t'(6), $urandom, $urandom, $urandom, 0, 1));
        send_request(make_request(op_code_t'(7), $urandom, $urandom, $urandom, 1, 0));
        req_valid <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();

        // Random phases: receiver-heavy idling, then sender-heavy, then none
        for (int p = 1; p <= PHASES; p++)
        begin
            if (p == 5)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 22;
            end
            if (p == 9)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            drain_responses();
            configure_phase(p);
            repeat (PHASE_REQUESTS) send_request(random_request());
            req_valid <= 1'b0;
        end

        drain_responses();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
